FILE: src/mstk_pkg.sv
// Package for the Kruskal spanning tree block: sizes, edge record type and
// helper types shared by the RAM users, the union-find unit and the top level.
// No dependencies.
package mstk_pkg;
	localparam int MAX_VERTICES = 16;
	localparam int MAX_EDGES = 64;
	localparam int WEIGHT_BITS = 16;
	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int CW = EW + 1;
	localparam int RANK_BITS = 3;
	localparam logic [RANK_BITS-1:0] RANK_MAX = '1;
	localparam int COST_W = 16;
	localparam int EDGE_W = 2 * VW + WEIGHT_BITS;

	typedef struct packed {
		logic [VW-1:0] from_v;
		logic [VW-1:0] to_v;
		logic signed [WEIGHT_BITS-1:0] cost;
	} edge_t;

	// Request to and answer from the union-find unit.
	typedef struct packed {
		logic start;
		logic [VW-1:0] a;
		logic [VW-1:0] b;
		logic init;
	} uf_req_t;

	typedef struct packed {
		logic done;
		logic joined;
	} uf_rsp_t;
endpackage

FILE: src/minimum_spanning_tree_kruskal_top.sv
// Kruskal spanning tree top level: edge RAM, insertion sort over an index RAM
// and scan driving the union-find unit. Depends on mstk_pkg, mstk_ram, mstk_uf.
// A non-final edge request is stored while idle. A final edge holds busy while all
// 64 index slots are set up, each edge is inserted and the sorted edges are scanned,
// each with a union-find walk that grows per tree level climbed, and a final step.
// Results cannot be stalled. Reset clears control state and the union-find tables.
module minimum_spanning_tree_kruskal_top (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_we,
	input logic [4:0] cfg_wdata,
	input logic [mstk_pkg::VW-1:0] edge_from,
	input logic [mstk_pkg::VW-1:0] edge_to,
	input logic signed [mstk_pkg::COST_W-1:0] edge_cost,
	input logic final_edge,
	output logic result_valid,
	output logic [mstk_pkg::VW-1:0] tree_from,
	output logic [mstk_pkg::VW-1:0] tree_to,
	output logic signed [mstk_pkg::COST_W-1:0] tree_cost,
	output logic tree_last,
	output logic tree_complete
);
	import mstk_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE, S_INIT, S_OUTER, S_RKEY, S_KEYW, S_RPREV, S_RPREVD, S_PRE, S_PREW,
		S_CMP, S_PUT, S_SRD, S_SRDI, S_SRDE, S_UF, S_FIN
	} state_t;

	state_t state_q;
	logic [4:0] vcnt_q;
	logic [CW-1:0] n_q, i_q, j_q, acc_q;
	logic [EW-1:0] key_q;
	logic signed [WEIGHT_BITS-1:0] kcost_q;
	edge_t cur_q, hold_q;

	logic e_we, o_we;
	logic [EW-1:0] e_addr, o_addr, o_wdata, o_rdata;
	logic [EDGE_W-1:0] e_wdata, e_rdata;
	edge_t e_rd;
	uf_req_t ufq;
	uf_rsp_t ufr;
	logic [VW:0] count;
	logic [VW:0] need;

	assign e_rd = edge_t'(e_rdata);
	assign count = (vcnt_q == 5'd0) ? (VW+1)'(1) :
		(vcnt_q > 5'(MAX_VERTICES)) ? (VW+1)'(MAX_VERTICES) : (VW+1)'(vcnt_q);
	assign need = count - 1'b1;
	assign busy = (state_q != S_IDLE);

	mstk_ram #(.WIDTH(EDGE_W), .DEPTH(MAX_EDGES)) u_edges (
		.clk, .we(e_we), .addr(e_addr), .wdata(e_wdata), .rdata(e_rdata));
	mstk_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_order (
		.clk, .we(o_we), .addr(o_addr), .wdata(o_wdata), .rdata(o_rdata));
	mstk_uf u_uf (.clk, .arst_n, .req(ufq), .rsp(ufr));

	always_comb begin
		e_we = 1'b0;
		e_addr = o_rdata;
		e_wdata = {edge_from, edge_to, edge_cost[WEIGHT_BITS-1:0]};
		o_we = 1'b0;
		o_addr = j_q[EW-1:0];
		o_wdata = key_q;
		ufq = '0;
		unique case (state_q)
			S_IDLE: begin
				e_addr = n_q[EW-1:0];
				e_we = start && (n_q < CW'(MAX_EDGES));
			end
			S_INIT: begin
				o_we = 1'b1;
				o_wdata = i_q[EW-1:0];
				o_addr = i_q[EW-1:0];
				ufq.init = 1'b1;
			end
			S_OUTER, S_RKEY: o_addr = i_q[EW-1:0];
			S_RPREV, S_RPREVD, S_PRE: o_addr = j_q[EW-1:0] - 1'b1;
			S_PUT: o_we = 1'b1;
			S_SRD: o_addr = i_q[EW-1:0];
			S_UF: begin
				ufq.a = cur_q.from_v;
				ufq.b = cur_q.to_v;
			end
			default: ;
		endcase
		// Shift step writes the previous slot's index up by one.
		if (state_q == S_CMP && j_q != '0 && e_rd.cost > kcost_q) begin
			o_we = 1'b1;
			o_wdata = o_rdata;
		end
		if (state_q == S_SRDE && (VW+1)'(e_rd.from_v) < count &&
			(VW+1)'(e_rd.to_v) < count) begin
			ufq.start = 1'b1;
			ufq.a = e_rd.from_v;
			ufq.b = e_rd.to_v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			vcnt_q <= 5'd16;
			n_q <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= 1'b0;
			if (cfg_we) begin
				vcnt_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (n_q < CW'(MAX_EDGES)) begin
							n_q <= n_q + 1'b1;
						end
						if (final_edge) begin
							i_q <= '0;
							state_q <= S_INIT;
						end
					end
				end
				S_INIT: begin
					if (i_q == CW'(MAX_EDGES - 1)) begin
						i_q <= CW'(1);
						state_q <= S_OUTER;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				S_OUTER: begin
					if (i_q >= n_q) begin
						i_q <= '0;
						acc_q <= '0;
						state_q <= S_SRD;
					end else begin
						state_q <= S_RKEY;
					end
				end
				S_RKEY: state_q <= S_KEYW;
				S_KEYW: begin
					key_q <= o_rdata;
					state_q <= S_PREW;
				end
				S_PREW: begin
					kcost_q <= e_rd.cost;
					j_q <= i_q;
					state_q <= S_RPREV;
				end
				S_RPREV: state_q <= S_RPREVD;
				S_RPREVD: state_q <= S_PRE;
				S_PRE: state_q <= (j_q == '0) ? S_PUT : S_CMP;
				S_CMP: begin
					if (j_q != '0 && e_rd.cost > kcost_q) begin
						j_q <= j_q - 1'b1;
						state_q <= (j_q == CW'(1)) ? S_PUT : S_RPREV;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					i_q <= i_q + 1'b1;
					state_q <= S_OUTER;
				end
				S_SRD: begin
					if (i_q >= n_q || acc_q >= CW'(need)) begin
						state_q <= S_FIN;
					end else begin
						state_q <= S_SRDI;
					end
				end
				S_SRDI: state_q <= S_SRDE;
				S_SRDE: begin
					cur_q <= e_rd;
					i_q <= i_q + 1'b1;
					if ((VW+1)'(e_rd.from_v) < count && (VW+1)'(e_rd.to_v) < count) begin
						state_q <= S_UF;
					end else begin
						state_q <= S_SRD;
					end
				end
				S_UF: begin
					if (ufr.done) begin
						// The newest accepted edge is held back so that the last one
						// can carry the end flags once the scan is over.
						if (ufr.joined) begin
							if (acc_q != '0) begin
								result_valid <= 1'b1;
								tree_from <= hold_q.from_v;
								tree_to <= hold_q.to_v;
								tree_cost <= hold_q.cost;
								tree_last <= 1'b0;
								tree_complete <= 1'b0;
							end
							hold_q <= cur_q;
							acc_q <= acc_q + 1'b1;
						end
						state_q <= S_SRD;
					end
				end
				S_FIN: begin
					n_q <= '0;
					state_q <= S_IDLE;
					result_valid <= 1'b1;
					tree_last <= 1'b1;
					if (acc_q == '0) begin
						tree_from <= '0;
						tree_to <= '0;
						tree_cost <= '0;
						tree_complete <= (need == '0);
					end else begin
						tree_from <= hold_q.from_v;
						tree_to <= hold_q.to_v;
						tree_cost <= hold_q.cost;
						tree_complete <= (acc_q == CW'(need));
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

FILE: src/mstk_ram.sv
// Generic single-port RAM with registered read.
// No dependencies.
module mstk_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(DEPTH)-1:0] addr,
	input logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

FILE: src/mstk_uf.sv
// Union-find unit: parent and rank tables in flip-flops, walks one step per
// cycle with path compression, union by rank. Depends on mstk_pkg.
module mstk_uf (
	input logic clk,
	input logic arst_n,
	input mstk_pkg::uf_req_t req,
	output mstk_pkg::uf_rsp_t rsp
);
	import mstk_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_FINDA, S_COMPA, S_FINDB, S_COMPB, S_JOIN
	} state_t;

	state_t state_q;
	logic [VW-1:0] parent_q [MAX_VERTICES];
	logic [RANK_BITS-1:0] rank_q [MAX_VERTICES];
	logic [VW-1:0] a_q, b_q, cur_q, ra_q, rb_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			rsp <= '0;
			for (int v = 0; v < MAX_VERTICES; v++) begin
				parent_q[v] <= VW'(v);
				rank_q[v] <= '0;
			end
		end else begin
			rsp.done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (req.init) begin
						for (int v = 0; v < MAX_VERTICES; v++) begin
							parent_q[v] <= VW'(v);
							rank_q[v] <= '0;
						end
					end else if (req.start) begin
						a_q <= req.a;
						b_q <= req.b;
						cur_q <= req.a;
						state_q <= S_FINDA;
					end
				end
				S_FINDA: begin
					if (parent_q[cur_q] == cur_q) begin
						ra_q <= cur_q;
						cur_q <= a_q;
						state_q <= S_COMPA;
					end else begin
						cur_q <= parent_q[cur_q];
					end
				end
				S_COMPA: begin
					// Point every node on the walked path straight at the root.
					if (cur_q == ra_q) begin
						cur_q <= b_q;
						state_q <= S_FINDB;
					end else begin
						parent_q[cur_q] <= ra_q;
						cur_q <= parent_q[cur_q];
					end
				end
				S_FINDB: begin
					if (parent_q[cur_q] == cur_q) begin
						rb_q <= cur_q;
						cur_q <= b_q;
						state_q <= S_COMPB;
					end else begin
						cur_q <= parent_q[cur_q];
					end
				end
				S_COMPB: begin
					if (cur_q == rb_q) begin
						state_q <= S_JOIN;
					end else begin
						parent_q[cur_q] <= rb_q;
						cur_q <= parent_q[cur_q];
					end
				end
				S_JOIN: begin
					rsp.done <= 1'b1;
					rsp.joined <= (ra_q != rb_q);
					state_q <= S_IDLE;
					if (ra_q != rb_q) begin
						if (rank_q[ra_q] < rank_q[rb_q]) begin
							parent_q[ra_q] <= rb_q;
						end else if (rank_q[ra_q] > rank_q[rb_q]) begin
							parent_q[rb_q] <= ra_q;
						end else begin
							parent_q[rb_q] <= ra_q;
							if (rank_q[ra_q] < RANK_MAX) begin
								rank_q[ra_q] <= rank_q[ra_q] + 1'b1;
							end
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_root: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_JOIN) |-> (parent_q[ra_q] == ra_q && parent_q[rb_q] == rb_q))
		else $error("union-find root is not its own parent");
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(state_q) == S_JOIN)
		else $error("done without join step");
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && req.start && !req.init) |=> state_q == S_FINDA)
		else $error("walk did not start");
`endif
endmodule
